>>> sv/rcfp_pkg.sv
`default_nettype none

package rcfp_pkg;

    localparam int CHANNEL_COUNT = 16;
    localparam int CHANNEL_BITS  = 11;
    localparam int PAYLOAD_BYTES = (CHANNEL_COUNT * CHANNEL_BITS) / 8;
    localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
    localparam int CH_IDX_W      = 4;
    localparam int POS_W         = 9;

    localparam logic [7:0] SYNC_RESET      = 8'hC8;
    localparam logic [7:0] POLY_RESET      = 8'hD5;
    localparam logic [7:0] CHANNELS_KIND   = 8'h16;
    localparam logic [7:0] CHANNELS_LENGTH = 8'd24;

    localparam logic CFG_SYNC = 1'b0;
    localparam logic CFG_POLY = 1'b1;

    localparam logic KIND_CHANNEL = 1'b0;
    localparam logic KIND_CRC_ERR = 1'b1;

    typedef struct packed {
        logic                 crc_err;
        logic [PAYLOAD_W-1:0] payload;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_SEND
    } back_state_t;

    function automatic logic [7:0] crc_update(input logic [7:0] crc,
                                              input logic [7:0] b,
                                              input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ poly;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> sv/rcfp_front.sv
`default_nettype none

module rcfp_front
    import rcfp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       byte_valid,
    input  wire logic [7:0] byte_data,
    input  wire logic       q_full,
    output logic            byte_ready,
    output logic            push,
    output cmd_t            push_cmd
);

    logic [7:0]           sync_reg;
    logic [7:0]           poly_reg;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [7:0]           len_reg, len_next;
    logic [7:0]           kind_reg, kind_next;
    logic [7:0]           crc_reg, crc_next;
    logic [PAYLOAD_W-1:0] payload_reg, payload_next;

    logic             accept;
    logic [POS_W-1:0] k;
    logic             qual;

    assign byte_ready = !q_full;
    assign accept     = byte_valid && byte_ready;
    assign k          = pos_reg - POS_W'(2);

    always_comb
    begin
        pos_next     = pos_reg;
        len_next     = len_reg;
        kind_next    = kind_reg;
        crc_next     = crc_reg;
        payload_next = payload_reg;
        qual         = 1'b0;
        push         = 1'b0;
        push_cmd     = '{crc_err: 1'b0, payload: payload_reg};
        if (accept)
        begin
            if (pos_reg == '0)
            begin
                if (byte_data == sync_reg)
                begin
                    pos_next = POS_W'(1);
                end
            end
            else if (pos_reg == POS_W'(1))
            begin
                len_next  = byte_data;
                kind_next = 8'd0;
                crc_next  = 8'd0;
                pos_next  = (byte_data == 8'd0) ? '0 : POS_W'(2);
            end
            else
            begin
                if (k == '0)
                begin
                    kind_next = byte_data;
                end
                crc_next = crc_update(crc_reg, byte_data, poly_reg);
                qual     = (kind_next == CHANNELS_KIND) && (len_reg == CHANNELS_LENGTH);
                if (qual && (k >= POS_W'(1)) && (k <= POS_W'(PAYLOAD_BYTES)))
                begin
                    payload_next = {byte_data, payload_reg[PAYLOAD_W-1:8]};
                end
                if (({1'b0, k} + 10'd1) < {2'b00, len_reg})
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
                else
                begin
                    pos_next = '0;
                    push     = qual;
                    push_cmd = '{crc_err: (crc_next != 8'd0), payload: payload_reg};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= SYNC_RESET;
            poly_reg <= POLY_RESET;
            pos_reg  <= '0;
            len_reg  <= 8'd0;
            kind_reg <= 8'd0;
            crc_reg  <= 8'd0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == CFG_SYNC))
            begin
                sync_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == CFG_POLY))
            begin
                poly_reg <= cfg_data;
            end
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            kind_reg <= kind_next;
            crc_reg  <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        payload_reg <= payload_next;
    end

endmodule

`default_nettype wire

>>> sv/rcfp_queue.sv
`default_nettype none

module rcfp_queue
    import rcfp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      full,
    output logic      head_valid,
    output cmd_t      head
);

    cmd_t       mem [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next    = do_push ? ~wr_reg : wr_reg;
        rd_next    = do_pop ? ~rd_reg : rd_reg;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> sv/rcfp_back.sv
`default_nettype none

module rcfp_back
    import rcfp_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    head_valid,
    input  wire cmd_t                    head,
    output logic                         pop,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         out_kind,
    output logic [CH_IDX_W-1:0]          out_index,
    output logic [CHANNEL_BITS-1:0]      out_value,
    output logic                         out_last
);

    back_state_t          state_reg, state_next;
    logic [CH_IDX_W-1:0]  cnt_reg, cnt_next;
    logic                 err_reg, err_next;
    logic [PAYLOAD_W-1:0] shift_reg, shift_next;
    logic                 last_word;

    assign last_word = err_reg || (cnt_reg == CH_IDX_W'(CHANNEL_COUNT - 1));
    assign out_valid = (state_reg == BK_SEND);
    assign out_kind  = err_reg ? KIND_CRC_ERR : KIND_CHANNEL;
    assign out_index = err_reg ? '0 : cnt_reg;
    assign out_value = err_reg ? '0 : shift_reg[CHANNEL_BITS-1:0];
    assign out_last  = last_word;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        shift_next = shift_reg;
        pop        = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid)
                begin
                    pop        = 1'b1;
                    cnt_next   = '0;
                    err_next   = head.crc_err;
                    shift_next = head.payload;
                    state_next = BK_SEND;
                end
            end
            BK_SEND:
            begin
                if (out_ready)
                begin
                    if (last_word)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + CH_IDX_W'(1);
                        shift_next = shift_reg >> CHANNEL_BITS;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            cnt_reg   <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

endmodule

`default_nettype wire

>>> sv/rc_channel_frame_parser.sv
// Channel  | Direction | Payload
// cfg      | in        | cfg_index: 0 sync byte, 1 CRC polynomial; cfg_data: 8-bit value
// s_axis   | in        | tdata: rx_byte
// m_axis   | out       | tdata: channel_index, channel_value; tuser: result_kind; tlast
//
// One received byte is taken per cycle while the frame queue has room.
// A frame's first result word is offered once the output stage pops it from the queue.
// A good frame yields sixteen words, one per cycle while tready is set; a bad CRC, one.
// The two-entry frame queue decouples the byte parser from result delivery.
// Reset is asynchronous and active low; the configuration port never stalls.
`default_nettype none

module rc_channel_frame_parser
    import rcfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // [3:0] channel_index, [14:4] channel_value
    output logic             m_axis_tuser,  // [0] result_kind
    output logic             m_axis_tlast
);

    logic                    push;
    cmd_t                    push_cmd;
    logic                    q_full;
    logic                    head_valid;
    cmd_t                    head;
    logic                    pop;
    logic [CH_IDX_W-1:0]     out_index;
    logic [CHANNEL_BITS-1:0] out_value;

    assign cfg_ready = 1'b1;

    rcfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_valid (s_axis_tvalid),
        .byte_data  (s_axis_tdata),
        .q_full     (q_full),
        .byte_ready (s_axis_tready),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    rcfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    rcfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_kind   (m_axis_tuser),
        .out_index  (out_index),
        .out_value  (out_value),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_value, out_index};

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("frame queue written while full");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_CRC_ERR)) |->
            (m_axis_tlast && (m_axis_tdata == 16'd0)))
        else $error("CRC error word malformed");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> m_axis_tvalid)
        else $error("frame taken from queue but no word presented");

endmodule

`default_nettype wire

>>> verif/rcfp_frame_checker.sv
`timescale 1ns / 100ps

package rcfp_tb_pkg;

    function automatic logic [7:0] crc8_next(input logic [7:0] acc,
                                             input logic [7:0] data_byte,
                                             input logic [7:0] gen);
        logic [7:0] r;
        r = acc ^ data_byte;
        repeat (8)
        begin
            r = r[7] ? ((r << 1) ^ gen) : (r << 1);
        end
        return r;
    endfunction

endpackage

module rcfp_frame_checker
    import rcfp_pkg::*;
    import rcfp_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          mismatch_count,
    output int          words_outstanding
);

    typedef struct packed {
        logic                kind;
        logic [CH_IDX_W-1:0] idx;
        logic [10:0]         value;
        logic                last;
    } channel_word_t;

    channel_word_t expected_words[$];

    logic [7:0]       sync_val;
    logic [7:0]       poly_val;
    logic [POS_W-1:0] position;
    logic [7:0]       frame_len;
    logic [7:0]       frame_type;
    logic [7:0]       crc_acc;
    logic [7:0]       payload_copy [PAYLOAD_BYTES];

    task automatic flag_word(input string what, input channel_word_t want,
                             input channel_word_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: %s: expected kind %0d index %0d value %0d last %0d,",
                     $time, what, want.kind, want.idx, want.value, want.last);
            $display("    got kind %0d index %0d value %0d last %0d",
                     got.kind, got.idx, got.value, got.last);
        end
    endtask

    task automatic take_byte(input logic [7:0] b);
        logic [PAYLOAD_W-1:0] flat;
        channel_word_t        w;
        int                   k;
        bit                   channels_frame;
        if (position == '0)
        begin
            if (b == sync_val)
            begin
                position = POS_W'(1);
            end
        end
        else if (position == POS_W'(1))
        begin
            frame_len  = b;
            frame_type = 8'h00;
            crc_acc    = 8'h00;
            position   = (b == 8'h00) ? '0 : POS_W'(2);
        end
        else
        begin
            k = position - 2;
            if (k == 0)
            begin
                frame_type = b;
            end
            crc_acc = crc8_next(crc_acc, b, poly_val);
            channels_frame = (frame_type == CHANNELS_KIND) && (frame_len == CHANNELS_LENGTH);
            if (channels_frame && k >= 1 && k <= PAYLOAD_BYTES)
            begin
                payload_copy[k - 1] = b;
            end
            if (k + 1 < frame_len)
            begin
                position = position + POS_W'(1);
            end
            else
            begin
                position = '0;
                if (channels_frame && crc_acc != 8'h00)
                begin
                    w.kind  = KIND_CRC_ERR;
                    w.idx   = '0;
                    w.value = '0;
                    w.last  = 1'b1;
                    expected_words.push_back(w);
                end
                else if (channels_frame)
                begin
                    for (int i = 0; i < PAYLOAD_BYTES; i++)
                    begin
                        flat[8 * i +: 8] = payload_copy[i];
                    end
                    for (int ch = 0; ch < CHANNEL_COUNT; ch++)
                    begin
                        w.kind  = KIND_CHANNEL;
                        w.idx   = CH_IDX_W'(ch);
                        w.value = flat[ch * CHANNEL_BITS +: CHANNEL_BITS];
                        w.last  = (ch == CHANNEL_COUNT - 1);
                        expected_words.push_back(w);
                    end
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        channel_word_t got;
        channel_word_t want;
        if (!rst_n)
        begin
            expected_words.delete();
            sync_val          = SYNC_RESET;
            poly_val          = POLY_RESET;
            position          = '0;
            frame_len         = 8'h00;
            frame_type        = 8'h00;
            crc_acc           = 8'h00;
            mismatch_count    = 0;
            words_outstanding = 0;
            for (int i = 0; i < PAYLOAD_BYTES; i++)
            begin
                payload_copy[i] = 8'h00;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SYNC)
                begin
                    sync_val = cfg_data;
                end
                else
                begin
                    poly_val = cfg_data;
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind  = m_axis_tuser;
                got.idx   = m_axis_tdata[3:0];
                got.value = m_axis_tdata[14:4];
                got.last  = m_axis_tlast;
                if (expected_words.size() == 0)
                begin
                    flag_word("word with nothing expected", '0, got);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got !== want)
                    begin
                        flag_word("word mismatch", want, got);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                take_byte(s_axis_tdata);
            end
            words_outstanding = expected_words.size();
        end
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import rcfp_pkg::*;
    import rcfp_tb_pkg::*;

    localparam int FILL_ZERO     = 0;
    localparam int FILL_ONES     = 1;
    localparam int FILL_RANDOM   = 2;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 4000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int          mismatch_count;
    int          words_outstanding;
    int          idle_cycles;
    int          hold_wanted;
    int          hold_served;
    bit          holding;
    bit          sender_idle_on;
    logic [7:0]  cur_sync;
    logic [7:0]  cur_poly;

    rc_channel_frame_parser i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    rcfp_frame_checker i_checker
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .m_axis_tuser      (m_axis_tuser),
        .m_axis_tlast      (m_axis_tlast),
        .mismatch_count    (mismatch_count),
        .words_outstanding (words_outstanding)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("rc_channel_frame_parser test failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The receiver takes a long hold-off whenever the stimulus asks for one.
    initial
    begin
        int burst;
        int stall;
        m_axis_tready = 1'b0;
        hold_served   = 0;
        holding       = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_wanted != hold_served)
            begin
                holding = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding = 1'b0;
                hold_served++;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(50, 150);
                stall = 0;
            end
            else
            begin
                burst = $urandom_range(1, 6);
                stall = random_gap();
            end
            m_axis_tready <= 1'b1;
            repeat (burst) @(posedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = sender_idle_on ? random_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        stop_sending();
        wait (words_outstanding == 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_SYNC)
        begin
            cur_sync = value;
        end
        else
        begin
            cur_poly = value;
        end
    endtask

    // The trailing byte is the CRC of type and body, so a clean frame checks to zero.
    task automatic send_frame(input logic [7:0] ftype, input logic [7:0] flen,
                              input int fill, input logic [7:0] crc_flip);
        logic [7:0] acc;
        logic [7:0] b;
        send_byte(cur_sync);
        send_byte(flen);
        if (flen != 8'h00)
        begin
            send_byte(ftype);
            acc = crc8_next(8'h00, ftype, cur_poly);
            for (int i = 0; i + 2 < flen; i++)
            begin
                if (fill == FILL_ZERO)
                begin
                    b = 8'h00;
                end
                else if (fill == FILL_ONES)
                begin
                    b = 8'hFF;
                end
                else
                begin
                    b = 8'($urandom);
                end
                send_byte(b);
                acc = crc8_next(acc, b, cur_poly);
            end
            if (flen > 8'd1)
            begin
                send_byte(acc ^ crc_flip);
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_SYNC;
        cfg_data       = 8'h00;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'h00;
        idle_cycles    = 0;
        hold_wanted    = 0;
        sender_idle_on = 1'b1;
        cur_sync       = SYNC_RESET;
        cur_poly       = POLY_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A stray byte, a zero-length frame, then a short frame that carries the sync value.
        send_byte(8'h00);
        send_frame(8'h00, 8'h00, FILL_RANDOM, 8'h00);
        send_byte(cur_sync);
        send_byte(8'd3);
        send_byte(CHANNELS_KIND);
        send_byte(cur_sync);
        send_byte(8'h55);

        // Frames back to back while the receiver holds off, so the input stalls.
        drain();
        hold_wanted++;
        wait (holding);
        @(posedge clk);
        sender_idle_on = 1'b0;
        send_frame(CHANNELS_KIND, CHANNELS_LENGTH, FILL_ONES, 8'h00);
        send_frame(CHANNELS_KIND, CHANNELS_LENGTH, FILL_ZERO, 8'h00);
        send_frame(CHANNELS_KIND, CHANNELS_LENGTH, FILL_RANDOM, 8'h01);
        send_frame(8'h17, CHANNELS_LENGTH, FILL_RANDOM, 8'h00);
        sender_idle_on = 1'b1;

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_SYNC, 8'($urandom));
        write_reg(CFG_POLY, 8'($urandom_range(1, 254)));
        send_frame(CHANNELS_KIND, CHANNELS_LENGTH, FILL_RANDOM, 8'h00);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && words_outstanding == 0)
        begin
            $display("rc_channel_frame_parser test passed");
        end
        else
        begin
            $display("rc_channel_frame_parser test failed");
        end
        $finish;
    end

endmodule
